>>> rtl/core/llc_pkg.sv
`timescale 1ns / 1ps

package llc_pkg;

  localparam int AVG_W   = 12;
  localparam int THR_W   = 12;
  localparam int WIN_W   = 11;
  localparam int LEVEL_W = 3;
  localparam int CMD_W   = 2;
  localparam int APB_AW  = 5;
  localparam int APB_DW  = 32;

  localparam logic [CMD_W-1:0] CMD_SAMPLE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RESTART = 2'd1;
  localparam logic [CMD_W-1:0] CMD_INIT    = 2'd2;

  localparam logic [LEVEL_W-1:0] LEVEL_ONE   = 3'd1;
  localparam logic [LEVEL_W-1:0] LEVEL_TWO   = 3'd2;
  localparam logic [LEVEL_W-1:0] LEVEL_THREE = 3'd3;
  localparam logic [LEVEL_W-1:0] LEVEL_FOUR  = 3'd4;

  localparam logic [2:0] REG_THR_LOW  = 3'd0;
  localparam logic [2:0] REG_THR_MID  = 3'd1;
  localparam logic [2:0] REG_THR_HIGH = 3'd2;
  localparam logic [2:0] REG_MARGIN   = 3'd3;
  localparam logic [2:0] REG_WINDOW   = 3'd4;

  typedef struct packed {
    logic [THR_W-1:0] thr_low;
    logic [THR_W-1:0] thr_mid;
    logic [THR_W-1:0] thr_high;
    logic [THR_W-1:0] margin;
    logic [WIN_W-1:0] window;
  } llc_cfg_t;

  typedef struct packed {
    logic load;
    logic step;
    logic div_step;
    logic decide;
    logic emit;
  } llc_cmd_t;

  typedef struct packed {
    logic sample_cmd;
    logic window_full;
    logic div_last;
  } llc_status_t;

endpackage

>>> rtl/core/llc_if.sv
`timescale 1ns / 1ps

interface llc_in_if #(
  parameter int SAMPLE_BITS = 12
);
  import llc_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [CMD_W-1:0]       cmd;
  logic [SAMPLE_BITS-1:0] sample;
  logic                   hold_level;

  modport source (output valid, cmd, sample, hold_level, input ready);
  modport sink   (input valid, cmd, sample, hold_level, output ready);
endinterface

interface llc_out_if;
  import llc_pkg::*;

  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] level;
  logic [AVG_W-1:0]   average;
  logic               window_done;
  logic               level_changed;

  modport source (output valid, level, average, window_done, level_changed, input ready);
  modport sink   (input valid, level, average, window_done, level_changed, output ready);
endinterface

>>> rtl/core/llc_regs.sv
`timescale 1ns / 1ps

module llc_regs (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [llc_pkg::APB_AW-1:0] paddr,
  input  logic [llc_pkg::APB_DW-1:0] pwdata,
  output logic [llc_pkg::APB_DW-1:0] prdata,
  output logic                      pready,
  output llc_pkg::llc_cfg_t         cfg
);
  import llc_pkg::*;

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_AW-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.thr_low  <= THR_W'(500);
      cfg.thr_mid  <= THR_W'(1500);
      cfg.thr_high <= THR_W'(3000);
      cfg.margin   <= THR_W'(50);
      cfg.window   <= WIN_W'(16);
    end else if (wr_en) begin
      case (reg_idx)
        REG_THR_LOW:  cfg.thr_low  <= pwdata[THR_W-1:0];
        REG_THR_MID:  cfg.thr_mid  <= pwdata[THR_W-1:0];
        REG_THR_HIGH: cfg.thr_high <= pwdata[THR_W-1:0];
        REG_MARGIN:   cfg.margin   <= pwdata[THR_W-1:0];
        REG_WINDOW:   cfg.window   <= pwdata[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_THR_LOW:  prdata = APB_DW'(cfg.thr_low);
      REG_THR_MID:  prdata = APB_DW'(cfg.thr_mid);
      REG_THR_HIGH: prdata = APB_DW'(cfg.thr_high);
      REG_MARGIN:   prdata = APB_DW'(cfg.margin);
      REG_WINDOW:   prdata = APB_DW'(cfg.window);
      default:      prdata = '0;
    endcase
  end

endmodule

>>> rtl/core/llc_dp.sv
`timescale 1ns / 1ps

module llc_dp #(
  parameter int SAMPLE_BITS = 12,
  parameter int MAX_WINDOW  = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  llc_pkg::llc_cfg_t             cfg,
  input  llc_pkg::llc_cmd_t             dp_cmd,
  output llc_pkg::llc_status_t          dp_status,
  input  logic [llc_pkg::CMD_W-1:0]     cmd,
  input  logic [SAMPLE_BITS-1:0]        sample,
  input  logic                          hold_level,
  output logic [llc_pkg::LEVEL_W-1:0]   out_level,
  output logic [llc_pkg::AVG_W-1:0]     out_average,
  output logic                          out_window_done,
  output logic                          out_level_changed
);
  import llc_pkg::*;

  localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_WINDOW);
  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int CMP_W = (WIN_W > CNT_W) ? WIN_W : CNT_W;
  localparam int DW    = (SUM_W > AVG_W) ? SUM_W : AVG_W;
  localparam int BIT_W = $clog2(DW);
  localparam int XW    = (SAMPLE_BITS > AVG_W) ? SAMPLE_BITS : AVG_W;

  function automatic logic [LEVEL_W-1:0] bracket_of(input logic [AVG_W-1:0] a,
                                                    input llc_cfg_t c);
    logic [LEVEL_W-1:0] r;
    if (a >= c.thr_high)     r = LEVEL_FOUR;
    else if (a < c.thr_low)  r = LEVEL_ONE;
    else if (a < c.thr_mid)  r = LEVEL_TWO;
    else                     r = LEVEL_THREE;
    return r;
  endfunction

  // captured word
  logic [CMD_W-1:0]       cmd_q;
  logic [SAMPLE_BITS-1:0] smp_q;
  logic                   hold_q;
  logic [LEVEL_W-1:0]     old_level;
  logic                   done_q;

  // block state
  logic [SUM_W-1:0]   sum;
  logic [CNT_W-1:0]   count;
  logic [LEVEL_W-1:0] level;
  logic [AVG_W-1:0]   last_avg;

  // divider
  logic [DW-1:0]    quo;
  logic [CNT_W-1:0] rem;
  logic [CNT_W-1:0] den;
  logic [BIT_W-1:0] bit_cnt;

  logic [SUM_W-1:0]   sum_inc;
  logic [CNT_W-1:0]   cnt_inc;
  logic [CMP_W-1:0]   win_eff;
  logic               full;
  logic [XW-1:0]      smp_x;
  logic [AVG_W-1:0]   init_avg;
  logic [CNT_W:0]     shifted;
  logic               ge;
  logic [CNT_W:0]     diff;
  logic [AVG_W-1:0]   avg;
  logic [LEVEL_W-1:0] target;
  logic [THR_W-1:0]   thr_up;
  logic [THR_W-1:0]   thr_dn;
  logic [THR_W+1:0]   margin_x;
  logic               rise_ok;
  logic               fall_ok;
  logic [LEVEL_W-1:0] level_next;

  assign sum_inc = sum + SUM_W'(smp_q);
  assign cnt_inc = count + 1'b1;
  assign win_eff = (CMP_W'(cfg.window) > CMP_W'(MAX_WINDOW)) ? CMP_W'(MAX_WINDOW)
                                                             : CMP_W'(cfg.window);
  assign full    = CMP_W'(cnt_inc) >= win_eff;
  assign smp_x    = XW'(smp_q);
  assign init_avg = smp_x[AVG_W-1:0];

  assign shifted = {rem, quo[DW-1]};
  assign ge      = shifted >= {1'b0, den};
  assign diff    = shifted - {1'b0, den};

  assign avg    = quo[AVG_W-1:0];
  assign target = bracket_of(avg, cfg);

  always_comb begin
    case (level)
      LEVEL_ONE: thr_up = cfg.thr_low;
      LEVEL_TWO: thr_up = cfg.thr_mid;
      default:   thr_up = cfg.thr_high;
    endcase
    case (target)
      LEVEL_ONE: begin
        thr_dn   = cfg.thr_low;
        margin_x = (THR_W+2)'(cfg.margin);
      end
      LEVEL_TWO: begin
        thr_dn   = cfg.thr_mid;
        margin_x = (THR_W+2)'(cfg.margin) << 1;
      end
      default: begin
        thr_dn   = cfg.thr_high;
        margin_x = (THR_W+2)'(cfg.margin) + ((THR_W+2)'(cfg.margin) << 1);
      end
    endcase
    // falling limit rewritten as avg + margin*target <= threshold
    rise_ok = {1'b0, avg} >= ({1'b0, thr_up} + {1'b0, cfg.margin});
    fall_ok = ((THR_W+3)'(avg) + (THR_W+3)'(margin_x)) <= (THR_W+3)'(thr_dn);
    level_next = level;
    if (target > level) begin
      if (rise_ok) level_next = target;
    end else if (target < level) begin
      if (fall_ok) level_next = target;
    end
  end

  assign dp_status.sample_cmd  = (cmd_q == CMD_SAMPLE);
  assign dp_status.window_full = full;
  assign dp_status.div_last    = (bit_cnt == '0);

  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      cmd_q     <= cmd;
      smp_q     <= sample;
      hold_q    <= hold_level;
      old_level <= level;
    end
    if (dp_cmd.step) begin
      quo     <= DW'(sum_inc);
      rem     <= '0;
      den     <= cnt_inc;
      bit_cnt <= BIT_W'(DW - 1);
    end else if (dp_cmd.div_step) begin
      quo     <= {quo[DW-2:0], ge};
      rem     <= ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
      bit_cnt <= bit_cnt - 1'b1;
    end
    if (dp_cmd.emit) begin
      out_level         <= level;
      out_average       <= last_avg;
      out_window_done   <= done_q;
      out_level_changed <= (level != old_level);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum      <= '0;
      count    <= '0;
      level    <= LEVEL_ONE;
      last_avg <= '0;
      done_q   <= 1'b0;
    end else if (dp_cmd.step) begin
      done_q <= 1'b0;
      case (cmd_q)
        CMD_SAMPLE: begin
          done_q <= full;
          if (full) begin
            sum   <= '0;
            count <= '0;
          end else begin
            sum   <= sum_inc;
            count <= cnt_inc;
          end
        end
        CMD_RESTART: begin
          sum   <= '0;
          count <= '0;
        end
        CMD_INIT: begin
          last_avg <= init_avg;
          level    <= bracket_of(init_avg, cfg);
        end
        default: ;
      endcase
    end else if (dp_cmd.decide) begin
      last_avg <= avg;
      if (!hold_q) level <= level_next;
    end
  end

endmodule

>>> rtl/core/llc_ctrl.sv
`timescale 1ns / 1ps

module llc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output llc_pkg::llc_cmd_t    dp_cmd,
  input  llc_pkg::llc_status_t dp_status
);
  import llc_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_STEP   = 3'd1;
  localparam logic [2:0] S_DIV    = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_EMIT   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_valid_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    dp_cmd     = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          dp_cmd.load = 1'b1;
          state_next  = S_STEP;
        end
      end
      S_STEP: begin
        dp_cmd.step = 1'b1;
        state_next  = (dp_status.sample_cmd && dp_status.window_full) ? S_DIV : S_EMIT;
      end
      S_DIV: begin
        dp_cmd.div_step = 1'b1;
        if (dp_status.div_last) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        dp_cmd.decide = 1'b1;
        state_next    = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid || out_ready) begin
          dp_cmd.emit = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    if (dp_cmd.emit)    out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
    else                out_valid_next = out_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.emit |-> (!out_valid || out_ready))
    else $error("result word overwritten before it was taken");

  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.emit |=> out_valid)
    else $error("result word not presented after emit");

  a_accept_step: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_STEP && !in_ready))
    else $error("accepted word not processed");

  a_div_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && dp_status.div_last) |=> dp_cmd.decide)
    else $error("decision missing after last divide step");

endmodule

>>> rtl/core/light_level_classifier_hysteresis_unit.sv
`timescale 1ns / 1ps

// Light level classifier. Each word on sensor carries a command (sample, restart window,
// initialize level), a sensor reading and a hold flag, and yields exactly one result word:
// the level 1..4, the last average, whether a window closed and whether the level moved.
// Samples are summed until window_samples (capped at MAX_WINDOW, zero acting as one) have
// arrived; the sum is then divided by the count and the average is sorted against the three
// thresholds with a rise margin and a per-level fall margin. A word that does not close a
// window passes through the step state to the result register; a window-closing sample
// also runs the restoring divider, which produces one quotient bit per cycle over a
// quotient of max(SAMPLE_BITS + clog2(MAX_WINDOW), 12) bits, and a decide state. One
// word is in work at a time; the next is accepted while the previous result waits on
// result.ready. Registers sit on the APB port at byte address 4*i (threshold_low,
// threshold_mid, threshold_high, hysteresis_margin, window_samples); pready is always high
// and writes belong to idle periods.

module light_level_classifier_hysteresis_unit #(
  parameter int SAMPLE_BITS = 12,
  parameter int MAX_WINDOW  = 1024
) (
  input  logic                       clk,
  input  logic                       rst,
  llc_in_if.sink                     sensor,
  llc_out_if.source                  result,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [llc_pkg::APB_AW-1:0] paddr,
  input  logic [llc_pkg::APB_DW-1:0] pwdata,
  output logic [llc_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);
  import llc_pkg::*;

  llc_cfg_t    cfg;
  llc_cmd_t    dp_cmd;
  llc_status_t dp_status;

  llc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  llc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sensor.valid),
    .in_ready  (sensor.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .dp_cmd    (dp_cmd),
    .dp_status (dp_status)
  );

  llc_dp #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_WINDOW  (MAX_WINDOW)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg               (cfg),
    .dp_cmd            (dp_cmd),
    .dp_status         (dp_status),
    .cmd               (sensor.cmd),
    .sample            (sensor.sample),
    .hold_level        (sensor.hold_level),
    .out_level         (result.level),
    .out_average       (result.average),
    .out_window_done   (result.window_done),
    .out_level_changed (result.level_changed)
  );

endmodule

>>> bench/light_level_classifier_hysteresis_unit_tb.sv
`timescale 1ns / 1ps

module light_level_classifier_hysteresis_unit_tb;
  import llc_pkg::*;

  localparam int SMP_W   = 12;
  localparam int MAX_WIN = 1024;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [SMP_W-1:0] sample;
    logic             hold;
  } sensor_word_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [AVG_W-1:0]   average;
    logic               window_done;
    logic               level_changed;
  } level_report_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic              pready;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;

  llc_in_if #(.SAMPLE_BITS(SMP_W)) sensor ();
  llc_out_if                       result ();

  light_level_classifier_hysteresis_unit #(
    .SAMPLE_BITS(SMP_W),
    .MAX_WINDOW (MAX_WIN)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .sensor (sensor),
    .result (result),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // classifier copy: configuration and state
  logic [THR_W-1:0]   thr [3];
  logic [THR_W-1:0]   margin_cfg;
  logic [WIN_W-1:0]   win_cfg;
  logic [21:0]        acc_sum;
  logic [WIN_W-1:0]   acc_cnt;
  logic [LEVEL_W-1:0] cur_level;
  logic [AVG_W-1:0]   last_avg;

  level_report_t expected_reports [$];

  int errors;
  int words_sent;
  int reports_checked;
  int windows_closed;
  int level_moves;
  bit no_idle;
  bit hold_off_req;

  function automatic logic [LEVEL_W-1:0] bracket_of_avg(input logic [AVG_W-1:0] avg);
    if (avg >= thr[2]) return LEVEL_FOUR;
    if (avg < thr[0]) return LEVEL_ONE;
    if (avg < thr[1]) return LEVEL_TWO;
    return LEVEL_THREE;
  endfunction

  function automatic level_report_t classify_word(input sensor_word_t w);
    level_report_t      r;
    logic [LEVEL_W-1:0] prior;
    logic [LEVEL_W-1:0] target;
    logic [LEVEL_W-1:0] nxt;
    int unsigned        win;
    int                 limit;
    prior = cur_level;
    r.window_done = 1'b0;
    case (w.cmd)
      CMD_SAMPLE: begin
        win = (win_cfg > MAX_WIN) ? MAX_WIN : int'(win_cfg);
        acc_sum += 22'(w.sample);
        acc_cnt += 1'b1;
        if (32'(acc_cnt) >= win) begin
          last_avg = AVG_W'(acc_sum / 22'(acc_cnt));
          target = bracket_of_avg(last_avg);
          nxt = cur_level;
          if (target > cur_level) begin
            if (int'(last_avg) >= int'(thr[(int'(cur_level) - 1) % 3]) + int'(margin_cfg))
              nxt = target;
          end else if (target < cur_level) begin
            limit = int'(thr[int'(target) - 1]) - int'(margin_cfg) * int'(target);
            if (int'(last_avg) <= limit) nxt = target;
          end
          if (!w.hold) cur_level = nxt;
          acc_sum = '0;
          acc_cnt = '0;
          r.window_done = 1'b1;
        end
      end
      CMD_RESTART: begin
        acc_sum = '0;
        acc_cnt = '0;
      end
      CMD_INIT: begin
        last_avg = w.sample;
        cur_level = bracket_of_avg(w.sample);
      end
      default: ;
    endcase
    r.level = cur_level;
    r.average = last_avg;
    r.level_changed = (cur_level != prior);
    return r;
  endfunction

  function automatic logic [APB_DW-1:0] reg_value(input logic [2:0] idx);
    case (idx)
      REG_THR_LOW:  return APB_DW'(thr[0]);
      REG_THR_MID:  return APB_DW'(thr[1]);
      REG_THR_HIGH: return APB_DW'(thr[2]);
      REG_MARGIN:   return APB_DW'(margin_cfg);
      REG_WINDOW:   return APB_DW'(win_cfg);
      default:      return '0;
    endcase
  endfunction

  function automatic logic [SMP_W-1:0] clamp_sample(input int v);
    if (v < 0) return '0;
    if (v > 4095) return '1;
    return SMP_W'(v);
  endfunction

  task automatic check_field(input string what, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, what, want, got);
      errors++;
    end
  endtask

  task automatic apb_access(input logic wr, input logic [2:0] idx,
                            input logic [APB_DW-1:0] wdata,
                            output logic [APB_DW-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [APB_DW-1:0] value);
    logic [APB_DW-1:0] wr_echo;
    logic [APB_DW-1:0] got;
    apb_access(1'b1, idx, value, wr_echo);
    case (idx)
      REG_THR_LOW:  thr[0] = value[THR_W-1:0];
      REG_THR_MID:  thr[1] = value[THR_W-1:0];
      REG_THR_HIGH: thr[2] = value[THR_W-1:0];
      REG_MARGIN:   margin_cfg = value[THR_W-1:0];
      REG_WINDOW:   win_cfg = value[WIN_W-1:0];
      default: ;
    endcase
    apb_access(1'b0, idx, '0, got);
    check_field("register readback", reg_value(idx), got);
  endtask

  task automatic apply_config(input logic [THR_W-1:0] lo, input logic [THR_W-1:0] mid,
                              input logic [THR_W-1:0] hi, input logic [THR_W-1:0] m,
                              input logic [WIN_W-1:0] win);
    write_reg(REG_THR_LOW, APB_DW'(lo));
    write_reg(REG_THR_MID, APB_DW'(mid));
    write_reg(REG_THR_HIGH, APB_DW'(hi));
    write_reg(REG_MARGIN, APB_DW'(m));
    write_reg(REG_WINDOW, APB_DW'(win));
  endtask

  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [SMP_W-1:0] smp,
                           input logic hold);
    sensor_word_t  w;
    level_report_t r;
    while (!no_idle && $urandom_range(0, 99) < 23) begin
      sensor.valid <= 1'b0;
      @(posedge clk);
    end
    w = '{cmd: cmd, sample: smp, hold: hold};
    sensor.valid      <= 1'b1;
    sensor.cmd        <= cmd;
    sensor.sample     <= smp;
    sensor.hold_level <= hold;
    @(posedge clk);
    while (!sensor.ready) @(posedge clk);
    r = classify_word(w);
    expected_reports.push_back(r);
    words_sent++;
    if (r.window_done) windows_closed++;
    if (r.level_changed) level_moves++;
  endtask

  task automatic wait_idle();
    sensor.valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_reset_values();
    logic [APB_DW-1:0] got;
    for (int i = REG_THR_LOW; i <= REG_WINDOW; i++) begin
      apb_access(1'b0, 3'(i), '0, got);
      check_field("reset value", reg_value(3'(i)), got);
    end
  endtask

  task automatic test_directed();
    apply_config(12'd500, 12'd1500, 12'd3000, 12'd50, 11'd1);
    send_word(CMD_INIT, 12'd0, 1'b0);
    send_word(CMD_INIT, 12'd4095, 1'b0);
    send_word(CMD_UNUSED, 12'd4095, 1'b1);
    send_word(CMD_INIT, 12'd1000, 1'b1);
    send_word(CMD_SAMPLE, 12'd4095, 1'b1);   // held: average updates, level stays
    send_word(CMD_SAMPLE, 12'd4095, 1'b0);
    send_word(CMD_SAMPLE, 12'd2990, 1'b0);
    send_word(CMD_SAMPLE, 12'd1300, 1'b0);
    send_word(CMD_SAMPLE, 12'd0, 1'b0);
    send_word(CMD_SAMPLE, 12'd549, 1'b0);    // just short of the rise margin
    send_word(CMD_SAMPLE, 12'd550, 1'b0);
    send_word(CMD_RESTART, 12'd4095, 1'b1);
    wait_idle();
    write_reg(REG_WINDOW, 32'd0);
    send_word(CMD_SAMPLE, 12'd3050, 1'b0);
    send_word(CMD_SAMPLE, 12'd0, 1'b1);
    wait_idle();
    write_reg(REG_WINDOW, 32'd3);
    send_word(CMD_SAMPLE, 12'd4095, 1'b0);
    send_word(CMD_SAMPLE, 12'd4095, 1'b0);
    send_word(CMD_RESTART, 12'd0, 1'b0);
    send_word(CMD_SAMPLE, 12'd0, 1'b0);
    send_word(CMD_SAMPLE, 12'd1, 1'b0);
    send_word(CMD_SAMPLE, 12'd2, 1'b0);
    wait_idle();
    // thresholds out of order, maximum margin
    apply_config(12'd3000, 12'd100, 12'd2000, 12'hFFF, 11'd3);
    send_word(CMD_INIT, 12'd2500, 1'b0);
    send_word(CMD_INIT, 12'd50, 1'b0);
    for (int n = 0; n < 3; n++) send_word(CMD_SAMPLE, 12'd4095, 1'b0);
    wait_idle();
  endtask

  task automatic test_random_configs();
    logic [THR_W-1:0] t [3];
    logic [THR_W-1:0] swap;
    logic [THR_W-1:0] m;
    logic [WIN_W-1:0] win;
    logic [CMD_W-1:0] c;
    logic [SMP_W-1:0] smp;
    int               aim;
    int               span;
    int               pick;
    for (int ph = 0; ph < 8; ph++) begin
      for (int k = 0; k < 3; k++) begin
        case ($urandom_range(0, 5))
          0:       t[k] = '0;
          1:       t[k] = '1;
          default: t[k] = THR_W'($urandom_range(0, 4095));
        endcase
      end
      if ($urandom_range(0, 3) != 0) begin
        for (int p = 0; p < 2; p++)
          for (int k = 0; k < 2 - p; k++)
            if (t[k] > t[k+1]) begin
              swap = t[k];
              t[k] = t[k+1];
              t[k+1] = swap;
            end
      end
      case ($urandom_range(0, 3))
        0:       m = THR_W'($urandom_range(0, 63));
        1:       m = THR_W'($urandom_range(0, 300));
        2:       m = THR_W'($urandom_range(0, 4095));
        default: m = '0;
      endcase
      win = ($urandom_range(0, 4) == 0) ? WIN_W'($urandom_range(0, 40))
                                        : WIN_W'($urandom_range(0, 6));
      if (ph < 2) begin
        for (int k = 0; k < 3; k++) t[k] = (ph == 0) ? '1 : '0;
        m = (ph == 0) ? '1 : '0;
        win = WIN_W'(ph);
      end
      apply_config(t[0], t[1], t[2], m, win);
      aim = 0;
      for (int n = 0; n < 110; n++) begin
        // walk the aim point around the thresholds so averages land near the margins
        if (n == 0 || $urandom_range(0, 7) == 0) begin
          span = int'(m) * 3 + 64;
          aim = int'(t[$urandom_range(0, 2)]) + int'($urandom_range(0, 2 * span)) - span;
        end
        pick = $urandom_range(0, 99);
        c = (pick < 85) ? CMD_SAMPLE : (pick < 90) ? CMD_RESTART :
            (pick < 96) ? CMD_INIT : CMD_UNUSED;
        smp = ($urandom_range(0, 7) == 0) ? SMP_W'($urandom_range(0, 4095))
                                          : clamp_sample(aim + int'($urandom_range(0, 16)) - 8);
        send_word(c, smp, 1'($urandom_range(0, 4) == 0));
      end
      wait_idle();
    end
  endtask

  task automatic test_saturated_window();
    apply_config(12'd800, 12'd2000, 12'd3200, 12'd100, 11'd2047);
    no_idle = 1'b1;
    send_word(CMD_RESTART, 12'd0, 1'b0);
    for (int n = 0; n < 1030; n++)
      send_word(CMD_SAMPLE, SMP_W'($urandom_range(1500, 4095)), 1'($urandom_range(0, 9) == 0));
    no_idle = 1'b0;
    wait_idle();
  endtask

  task automatic test_output_stall();
    apply_config(12'd500, 12'd1500, 12'd3000, 12'd20, 11'd1);
    hold_off_req = 1'b1;
    for (int n = 0; n < 40; n++)
      send_word(CMD_SAMPLE, SMP_W'($urandom_range(0, 4095)), 1'($urandom_range(0, 3) == 0));
    wait_idle();
  endtask

  // result sink with random stalls and one long hold-off
  initial begin
    result.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        result.ready <= 1'b0;
        for (int n = 0; n < 300; n++) @(posedge clk);
      end
      result.ready <= no_idle || ($urandom_range(0, 99) >= 23);
    end
  end

  always @(posedge clk) begin : report_check
    level_report_t want;
    if (!rst && result.valid && result.ready) begin
      if (expected_reports.size() == 0) begin
        $display("%0t ns: unexpected word, expected none actual level %0d average %0d",
                 $time, result.level, result.average);
        errors++;
      end else begin
        want = expected_reports.pop_front();
        check_field("level", 32'(want.level), 32'(result.level));
        check_field("average", 32'(want.average), 32'(result.average));
        check_field("window_done", 32'(want.window_done), 32'(result.window_done));
        check_field("level_changed", 32'(want.level_changed), 32'(result.level_changed));
        reports_checked++;
      end
    end
  end

  initial begin
    rst               <= 1'b1;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    sensor.valid      <= 1'b0;
    sensor.cmd        <= CMD_SAMPLE;
    sensor.sample     <= '0;
    sensor.hold_level <= 1'b0;
    thr[0]     = 12'd500;
    thr[1]     = 12'd1500;
    thr[2]     = 12'd3000;
    margin_cfg = 12'd50;
    win_cfg    = 11'd16;
    acc_sum    = '0;
    acc_cnt    = '0;
    cur_level  = LEVEL_ONE;
    last_avg   = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_values();
    test_directed();
    test_random_configs();
    test_saturated_window();
    test_output_stall();
    repeat (40) @(posedge clk);
    if (expected_reports.size() != 0) begin
      $display("%0t ns: %0d results never arrived", $time, expected_reports.size());
      errors++;
    end
    $display("Sent %0d sensor words, checked %0d results: %0d windows closed, %0d level moves.",
             words_sent, reports_checked, windows_closed, level_moves);
    $display("Register sets: directed edges, 8 random, saturated window, long output stall.");
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/llc_pkg.sv
rtl/core/llc_if.sv
rtl/core/llc_regs.sv
rtl/core/llc_dp.sv
rtl/core/llc_ctrl.sv
rtl/core/light_level_classifier_hysteresis_unit.sv
bench/light_level_classifier_hysteresis_unit_tb.sv
